// ===== src/stream_name_pair_encoder_assert.svh =====
// Assertion macros used by the name pair encoder result queue.
`ifndef STREAM_NAME_PAIR_ENCODER_ASSERT_SVH
`define STREAM_NAME_PAIR_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define SNPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SNPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SNPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SNPE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/snpe_pkg.sv =====
// Types, constants and the character map of the name pair encoder.
`default_nettype none

package snpe_pkg;

    localparam logic [15:0] TableMark = 16'h4840;
    localparam logic [15:0] LoneBase  = 16'h4800;
    localparam logic [15:0] PairBase  = 16'h3800;

    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;
    localparam int FifoCw    = 3;

    typedef struct packed {
        logic        ok;
        logic [5:0]  code;
    } t_map;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic        complete;
    } t_result;

    // Up to two results produced by one character, in order r0 then r1.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_map map_char(input logic [15:0] c);
        t_map m;
        m.ok   = 1'b1;
        m.code = 6'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            m.code = 6'(c - 16'h0030);
        end else if (c >= 16'h0041 && c <= 16'h005a) begin
            m.code = 6'(c - 16'h0041 + 16'd10);
        end else if (c >= 16'h0061 && c <= 16'h007a) begin
            m.code = 6'(c - 16'h0061 + 16'd36);
        end else if (c == 16'h002e) begin
            m.code = 6'd62;
        end else if (c == 16'h005f) begin
            m.code = 6'd63;
        end else begin
            m.ok = 1'b0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/stream_name_pair_encoder.sv =====
// Top level of the stream name pair encoder.
//
//  Group     Dir  Width  Contents
//  s (in)    in   16     tdata: name_char[15:0]
//  m (out)   out  16+1+1 tdata: code_unit[15:0]; tlast: last; tuser: complete
//  cfg       in   1      table_mode write
//
//  A character is held in the input register and is then encoded into the result
//  queue once the queue has room; output beats are read from the queue registers.
//  One character is accepted per cycle while the queue has room for two results;
//  sustained rate is limited only by the output taking one beat per cycle.
//  Reset is synchronous on i_rst_n low; table_mode returns to 1.
//  A stall on the output fills the queue, and the input then stalls in turn.
`default_nettype none

module stream_name_pair_encoder #(
    parameter int MAX_NAME_UNITS = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] name_char
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] code_unit
    output logic             o_m_tlast,
    output logic             o_m_tuser,   // [0] complete
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data
);
    import snpe_pkg::*;

    logic    r_table_mode;
    logic    room;
    t_push   push;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_table_mode <= i_cfg_wr_data;
        end
    end

    snpe_core #(
        .MAX_NAME_UNITS(MAX_NAME_UNITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_table_mode(r_table_mode),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_char      (i_s_tdata),
        .i_room      (room),
        .o_push      (push)
    );

    snpe_out_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_res  (res)
    );

    assign o_m_tdata = res.unit;
    assign o_m_tlast = res.last;
    assign o_m_tuser = res.complete;

endmodule

`default_nettype wire

// ===== src/snpe_core.sv =====
// Input register and per-character encoding with the name state.
`default_nettype none

module snpe_core #(
    parameter int MAX_NAME_UNITS = 31
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_table_mode,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [15:0]    i_char,
    input  wire logic           i_room,
    output snpe_pkg::t_push     o_push
);
    import snpe_pkg::*;

    localparam int UW = $clog2(MAX_NAME_UNITS + 1);
    localparam logic [UW-1:0] MaxUnits = UW'(MAX_NAME_UNITS);

    logic          r_in_valid;
    logic [15:0]   r_in_char;
    logic          r_pend_v, n_pend_v;
    logic [5:0]    r_pend_code, n_pend_code;
    logic [UW-1:0] r_units, n_units;
    logic          r_started, n_started;
    logic          r_disc, n_disc;

    logic          advance;
    t_map          cmap;
    logic          mv;
    logic [UW-1:0] uu_a, uu_b;
    logic          pre_v, fin_v;
    t_result       pre, fin;

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || advance;
    assign cmap    = map_char(r_in_char);
    assign mv      = (r_in_char != 16'd0) && cmap.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_char <= i_char;
        end
    end

    always_comb begin
        n_pend_v    = r_pend_v;
        n_pend_code = r_pend_code;
        n_units     = r_units;
        n_started   = r_started;
        n_disc      = r_disc;
        uu_a        = r_started ? r_units : (i_table_mode ? UW'(1) : UW'(0));
        uu_b        = uu_a;
        pre_v       = 1'b0;
        pre         = '{unit: TableMark, last: 1'b0, complete: 1'b0};
        fin_v       = 1'b0;
        fin         = '{unit: 16'd0, last: 1'b1, complete: 1'b0};
        if (r_disc) begin
            // Rest of a cut-off name is dropped up to its zero.
            if (r_in_char == 16'd0) begin
                n_pend_v  = 1'b0;
                n_units   = '0;
                n_started = 1'b0;
                n_disc    = 1'b0;
            end
        end else begin
            n_started = 1'b1;
            pre_v     = !r_started && i_table_mode;
            if (r_pend_v && mv) begin
                pre.unit = PairBase + {10'd0, r_pend_code} + {4'd0, cmap.code, 6'd0};
                pre_v    = 1'b1;
                n_pend_v = 1'b0;
                n_units  = uu_a + UW'(1);
            end else begin
                if (r_pend_v) begin
                    pre.unit = LoneBase + {10'd0, r_pend_code};
                    pre_v    = 1'b1;
                    n_pend_v = 1'b0;
                    uu_b     = uu_a + UW'(1);
                end
                n_units = uu_b;
                if (uu_b >= MaxUnits) begin
                    fin_v = 1'b1;
                    if (r_in_char == 16'd0) begin
                        n_units   = '0;
                        n_started = 1'b0;
                    end else begin
                        n_disc = 1'b1;
                    end
                end else if (r_in_char == 16'd0) begin
                    fin_v        = 1'b1;
                    fin.complete = 1'b1;
                    n_units      = '0;
                    n_started    = 1'b0;
                end else if (mv) begin
                    n_pend_v    = 1'b1;
                    n_pend_code = cmap.code;
                end else begin
                    fin_v    = 1'b1;
                    fin.unit = r_in_char;
                    fin.last = 1'b0;
                    n_units  = uu_b + UW'(1);
                end
            end
        end
    end

    always_comb begin
        o_push.r1 = fin;
        if (pre_v) begin
            o_push.r0  = pre;
            o_push.cnt = fin_v ? 2'd2 : 2'd1;
        end else begin
            o_push.r0  = fin;
            o_push.cnt = fin_v ? 2'd1 : 2'd0;
        end
        if (!advance) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_pend_code <= '0;
            r_units     <= '0;
            r_started   <= 1'b0;
            r_disc      <= 1'b0;
        end else if (advance) begin
            r_pend_v    <= n_pend_v;
            r_pend_code <= n_pend_code;
            r_units     <= n_units;
            r_started   <= n_started;
            r_disc      <= n_disc;
        end
    end

endmodule

`default_nettype wire

// ===== src/snpe_out_fifo.sv =====
// Four-entry result queue taking up to two results a beat and giving one.
`default_nettype none
`include "stream_name_pair_encoder_assert.svh"

module snpe_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  snpe_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output snpe_pkg::t_result   o_res
);
    import snpe_pkg::*;

    t_result           r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wp;
    logic [FifoAw-1:0] r_rp;
    logic [FifoCw-1:0] r_count;
    logic              pop;

    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // Room for the worst case of two results from the next character.
    assign o_room  = r_count <= FifoCw'(FifoDepth - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + FifoAw'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + FifoAw'(i_push.cnt);
            r_rp    <= r_rp + FifoAw'(pop);
            r_count <= r_count + FifoCw'(i_push.cnt) - FifoCw'(pop);
        end
    end

    `SNPE_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || r_count <= FifoCw'(FifoDepth), "queue count beyond depth")
    `SNPE_ASSERT(a_no_overrun, i_clk, i_rst_n, (FifoCw'(i_push.cnt) + r_count) <= FifoCw'(FifoDepth), "push overruns queue")
    `SNPE_ASSERT(a_double_push, i_clk, i_rst_n, (i_push.cnt == 2'd2 && !pop) |=> r_count == $past(r_count) + FifoCw'(2), "double push not counted")

endmodule

`default_nettype wire
